/* rtl/lsdrs_pkg.sv */
// ----------------------------------------------------------------------------
// lsdrs_pkg
// Shared widths, constants and the digit extraction used by the radix sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package lsdrs_pkg;

  // Element and digit geometry
  localparam int DATA_W      = 32;
  localparam int DIGIT_W     = 8;
  localparam int NUM_BUCKETS = 256;
  localparam int BKT_AW      = 8;
  localparam int BKT_SWEEP_W = 9;   // holds NUM_BUCKETS itself
  localparam int PASS_W      = 3;   // up to eight byte passes

  // Bias on the top digit: signed byte plus 128
  localparam logic [DIGIT_W-1:0] TOP_BIAS = 8'h80;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_ELEMS    = 64;
  localparam int DEF_DIGIT_PASSES = 4;

  // Byte digit of a sign-extended element; top pass flips the sign bit
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [DATA_W-1:0] v,
                                                 input logic [PASS_W-1:0] pass,
                                                 input logic top);
    logic [DIGIT_W-1:0] b;
    unique case (pass[1:0])
      2'd0:    b = v[7:0];
      2'd1:    b = v[15:8];
      2'd2:    b = v[23:16];
      default: b = v[31:24];
    endcase
    if (pass[2]) b = {DIGIT_W{v[DATA_W-1]}};
    if (top) b = b ^ TOP_BIAS;
    return b;
  endfunction

endpackage

`default_nettype wire

/* rtl/lsdrs_ram.sv */
// ----------------------------------------------------------------------------
// lsdrs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module lsdrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read the old contents; hold the read word when idle
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/lsd_byte_radix_sort_top.sv */
// ----------------------------------------------------------------------------
// lsd_byte_radix_sort_top
// Collects signed 32-bit words until one marked last, sorts them ascending
// with an LSD radix sort over byte digits and streams the result out.
// ----------------------------------------------------------------------------
// Words are taken one a cycle into the primary buffer until a word marked
// last; words beyond MAX_ELEMS are dropped, a dropped last word still starts
// the sort. Each of DIGIT_PASSES passes runs a clear of the bucket counter
// RAM, a pipelined count over the N stored words, a prefix sweep and a
// pipelined scatter into the other buffer; bucket read-modify-writes to the
// same counter in back-to-back cycles are forwarded. The sorted set then
// leaves at one word a cycle while out_ready is high, with the final word
// marked by last_res. No input is taken from the first last word until the
// final sorted word has been taken.
`default_nettype none

module lsd_byte_radix_sort_top #(
  parameter int MAX_ELEMS    = lsdrs_pkg::DEF_MAX_ELEMS,
  parameter int DIGIT_PASSES = lsdrs_pkg::DEF_DIGIT_PASSES
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [lsdrs_pkg::DATA_W-1:0]   value,
  input  wire logic                                  last,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [lsdrs_pkg::DATA_W-1:0]        sorted_value,
  output logic                                       last_res
);

  import lsdrs_pkg::*;

  localparam int AW = $clog2(MAX_ELEMS);
  localparam int CW = $clog2(MAX_ELEMS + 1);

  typedef enum logic [2:0] {
    S_LOAD, S_CLEAR, S_COUNT, S_PREFIX, S_SCATTER, S_EMIT
  } state_t;

  state_t state;

  logic [CW-1:0]          elem_cnt;
  logic [PASS_W-1:0]      pass_idx;
  logic                   src_sel;     // 0: primary is source, 1: secondary
  logic [CW-1:0]          idx;
  logic [BKT_SWEEP_W-1:0] bkt;
  logic [CW-1:0]          run;

  // Element pipeline: stage 1 has buffer data, stage 2 has bucket data
  logic                   s1_valid;
  logic                   s2_valid;
  logic [DIGIT_W-1:0]     s2_digit;
  logic [DATA_W-1:0]      s2_value;
  logic                   fwd_valid;
  logic [DIGIT_W-1:0]     fwd_addr;
  logic [CW-1:0]          fwd_data;

  // Prefix pipeline
  logic                   pf_valid;
  logic [BKT_AW-1:0]      pf_addr;

  // Memory ports
  logic                   a_we, b_we, buf_re;
  logic [AW-1:0]          a_waddr, b_waddr, buf_raddr;
  logic [DATA_W-1:0]      a_wdata, b_wdata, a_rdata, b_rdata, rd_data;
  logic                   bk_we, bk_re;
  logic [BKT_AW-1:0]      bk_waddr, bk_raddr;
  logic [CW-1:0]          bk_wdata, bk_rdata;

  logic                   elem_phase, in_acc, top_pass, issue, emit_issue;
  logic [DIGIT_W-1:0]     s1_digit;
  logic [CW-1:0]          cur, cur_inc;

  assign in_ready   = (state == S_LOAD);
  assign in_acc     = in_valid && in_ready;
  assign elem_phase = (state == S_COUNT) || (state == S_SCATTER);
  assign top_pass   = (pass_idx == PASS_W'(DIGIT_PASSES - 1));
  assign issue      = idx < elem_cnt;
  assign emit_issue = issue && (!out_valid || out_ready);

  assign rd_data      = src_sel ? b_rdata : a_rdata;
  assign sorted_value = $signed(rd_data);
  assign s1_digit     = digit_of(rd_data, pass_idx, top_pass);

  // Counter value seen by stage 2, forwarded from last cycle's write
  assign cur     = (fwd_valid && fwd_addr == s2_digit) ? fwd_data : bk_rdata;
  assign cur_inc = cur + CW'(1);

  // Drive the buffer RAM ports
  always_comb begin
    a_we      = 1'b0;
    a_waddr   = elem_cnt[AW-1:0];
    a_wdata   = value;
    b_we      = 1'b0;
    b_waddr   = cur[AW-1:0];
    b_wdata   = s2_value;
    buf_raddr = idx[AW-1:0];
    buf_re    = 1'b0;
    case (state)
      S_LOAD: begin
        a_we = in_acc && (elem_cnt < CW'(MAX_ELEMS));
      end
      S_COUNT: begin
        buf_re = issue;
      end
      S_SCATTER: begin
        buf_re = issue;
        if (src_sel) begin
          a_we    = s2_valid;
          a_waddr = cur[AW-1:0];
          a_wdata = s2_value;
        end else begin
          b_we = s2_valid;
        end
      end
      S_EMIT: begin
        buf_re = emit_issue;
      end
      default: begin
      end
    endcase
  end

  // Drive the bucket counter RAM ports
  always_comb begin
    bk_we    = 1'b0;
    bk_waddr = s2_digit;
    bk_wdata = cur_inc;
    bk_re    = 1'b0;
    bk_raddr = s1_digit;
    case (state)
      S_CLEAR: begin
        bk_we    = 1'b1;
        bk_waddr = bkt[BKT_AW-1:0];
        bk_wdata = '0;
      end
      S_COUNT, S_SCATTER: begin
        bk_we = s2_valid;
        bk_re = s1_valid;
      end
      S_PREFIX: begin
        bk_we    = pf_valid;
        bk_waddr = pf_addr;
        bk_wdata = run;
        bk_re    = !bkt[BKT_SWEEP_W-1];
        bk_raddr = bkt[BKT_AW-1:0];
      end
      default: begin
      end
    endcase
  end

  lsdrs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMS)) u_primary (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .re(buf_re), .raddr(buf_raddr), .rdata(a_rdata)
  );

  lsdrs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMS)) u_secondary (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .re(buf_re), .raddr(buf_raddr), .rdata(b_rdata)
  );

  lsdrs_ram #(.WIDTH(CW), .DEPTH(NUM_BUCKETS)) u_buckets (
    .clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
    .re(bk_re), .raddr(bk_raddr), .rdata(bk_rdata)
  );

  // Sequencer: state, counters, pipeline flags and the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      elem_cnt  <= '0;
      pass_idx  <= '0;
      src_sel   <= 1'b0;
      idx       <= '0;
      bkt       <= '0;
      run       <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      pf_valid  <= 1'b0;
      out_valid <= 1'b0;
      last_res  <= 1'b0;
    end else begin
      // Advance the element pipeline
      s1_valid  <= elem_phase && issue;
      s2_valid  <= elem_phase && s1_valid;
      fwd_valid <= elem_phase && s2_valid;
      s2_digit  <= s1_digit;
      s2_value  <= rd_data;
      fwd_addr  <= s2_digit;
      fwd_data  <= cur_inc;

      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (elem_cnt < CW'(MAX_ELEMS)) elem_cnt <= elem_cnt + CW'(1);
            if (last) begin
              state    <= S_CLEAR;
              bkt      <= '0;
              pass_idx <= '0;
              src_sel  <= 1'b0;
            end
          end
        end
        S_CLEAR: begin
          bkt <= bkt + BKT_SWEEP_W'(1);
          if (bkt[BKT_AW-1:0] == BKT_AW'(NUM_BUCKETS - 1)) begin
            state <= S_COUNT;
            idx   <= '0;
          end
        end
        S_COUNT: begin
          if (issue) begin
            idx <= idx + CW'(1);
          end else if (!s1_valid && !s2_valid) begin
            state    <= S_PREFIX;
            bkt      <= '0;
            run      <= '0;
            pf_valid <= 1'b0;
          end
        end
        S_PREFIX: begin
          pf_valid <= !bkt[BKT_SWEEP_W-1];
          pf_addr  <= bkt[BKT_AW-1:0];
          if (!bkt[BKT_SWEEP_W-1]) bkt <= bkt + BKT_SWEEP_W'(1);
          if (pf_valid) run <= run + bk_rdata;
          if (bkt[BKT_SWEEP_W-1] && !pf_valid) begin
            state <= S_SCATTER;
            idx   <= '0;
          end
        end
        S_SCATTER: begin
          if (issue) begin
            idx <= idx + CW'(1);
          end else if (!s1_valid && !s2_valid) begin
            src_sel <= !src_sel;
            idx     <= '0;
            bkt     <= '0;
            if (top_pass) begin
              state <= S_EMIT;
            end else begin
              state    <= S_CLEAR;
              pass_idx <= pass_idx + PASS_W'(1);
            end
          end
        end
        S_EMIT: begin
          if (emit_issue) begin
            idx       <= idx + CW'(1);
            out_valid <= 1'b1;
            last_res  <= (idx + CW'(1) == elem_cnt);
          end else if (out_valid && out_ready) begin
            out_valid <= 1'b0;
            if (last_res) begin
              state    <= S_LOAD;
              elem_cnt <= '0;
              pass_idx <= '0;
              src_sel  <= 1'b0;
              idx      <= '0;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // The stored set never outgrows the buffers
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    elem_cnt <= CW'(MAX_ELEMS))
    else $error("element count beyond buffer depth");

  // The prefix sweep accounts for every stored word
  a_prefix_total: assert property (@(posedge clk) disable iff (rst)
    (state == S_PREFIX && bkt[BKT_SWEEP_W-1] && !pf_valid) |-> run == elem_cnt)
    else $error("bucket counts do not sum to element count");

  // Every scatter slot lies inside the stored set
  a_scatter_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCATTER && s2_valid) |-> cur < elem_cnt)
    else $error("scatter offset outside the set");

  // Taking the final sorted word returns the block to loading
  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_valid && out_ready && last_res && !emit_issue)
      |=> (state == S_LOAD && elem_cnt == '0))
    else $error("block did not return to loading after the final word");

  // Sorted words appear only while emitting
  a_out_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_EMIT)
    else $error("output word outside the emit phase");

endmodule

`default_nettype wire

/* tb/lsd_byte_radix_sort_top_tb.sv */
// ----------------------------------------------------------------------------
// lsd_byte_radix_sort_top_tb
// Self-checking bench for the byte-digit radix sorter. Sets of signed words
// go in with random spacing, the output side stalls at random, and every
// sorted word is checked in order against a local LSD radix sort of the set.
// ----------------------------------------------------------------------------
module lsd_byte_radix_sort_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsdrs_pkg::*;

  localparam int SET_CAP      = DEF_MAX_ELEMS;
  localparam int SORT_PASSES  = DEF_DIGIT_PASSES;
  localparam int ITEM_TARGET  = 360;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic              last;
    int                gap;
    bit                drain;
  } feed_word_t;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic              last;
  } sorted_word_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] value = '0;
  logic                     last = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     last_res;

  feed_word_t        feed_q[$];
  sorted_word_t      sorted_q[$];
  logic [DATA_W-1:0] set_buf [SET_CAP];
  int                set_len = 0;
  int                fault_count = 0;
  logic              in_fire = 1'b0;
  int                gap_left = 0;
  int                stall_left = 0;
  int                calm_left = 0;
  bit                calm_feed = 1'b0;
  bit                drain_next = 1'b0;
  int                feed_pos = 0;
  int                made_items = 0;

  lsd_byte_radix_sort_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .value        (value),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sorted_value (sorted_value),
    .last_res     (last_res)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // hold reset from the start, release it on a falling edge
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // mostly short idles, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // byte digit of the sign-extended word; top pass flips the sign bit
  function automatic logic [DIGIT_W-1:0] byte_digit(logic [DATA_W-1:0] v, int pass_no);
    logic [63:0]        wide;
    logic [DIGIT_W-1:0] b;
    wide = {{32{v[DATA_W-1]}}, v};
    b = wide[pass_no*8 +: 8];
    if (pass_no == SORT_PASSES - 1) b = b ^ TOP_BIAS;
    return b;
  endfunction

  // collect a word; on last, radix-sort the set and queue the sorted words
  task automatic absorb_word(input logic [DATA_W-1:0] v, input logic l);
    logic [DATA_W-1:0]  src [SET_CAP];
    logic [DATA_W-1:0]  dst [SET_CAP];
    int                 bucket [NUM_BUCKETS];
    int                 run;
    int                 c;
    logic [DIGIT_W-1:0] d;
    sorted_word_t       w;
    if (set_len < SET_CAP) begin
      set_buf[set_len] = v;
      set_len++;
    end
    if (l) begin
      src = set_buf;
      dst = set_buf;
      for (int p = 0; p < SORT_PASSES; p++) begin
        for (int b = 0; b < NUM_BUCKETS; b++) bucket[b] = 0;
        for (int i = 0; i < set_len; i++) bucket[byte_digit(src[i], p)]++;
        run = 0;
        for (int b = 0; b < NUM_BUCKETS; b++) begin
          c = bucket[b];
          bucket[b] = run;
          run += c;
        end
        // stable scatter into the other buffer
        for (int i = 0; i < set_len; i++) begin
          d = byte_digit(src[i], p);
          dst[bucket[d]] = src[i];
          bucket[d]++;
        end
        src = dst;
      end
      for (int i = 0; i < set_len; i++) begin
        w.value = src[i];
        w.last  = (i == set_len - 1);
        sorted_q.push_back(w);
      end
      set_len = 0;
    end
  endtask

  // random element: full range, near zero, corner values or a shared top part
  function automatic logic [DATA_W-1:0] rand_value(int style, logic [DATA_W-1:0] base);
    logic [DATA_W-1:0] v;
    if ($urandom_range(0, 7) == 0) style = $urandom_range(0, 3);
    case (style)
      0: v = $urandom;
      1: v = DATA_W'($urandom_range(0, 600)) - 32'd300;
      2: begin
        case ($urandom_range(0, 7))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          3: v = 32'hFFFF_FFFF;
          4: v = 32'h0000_0001;
          5: v = 32'h0000_0080;
          6: v = 32'hFFFF_FF7F;
          default: v = 32'h80 << (8 * $urandom_range(0, 3));
        endcase
      end
      default: begin
        if ($urandom_range(0, 1) == 0) v = {base[31:8], 8'($urandom)};
        else v = {base[31:16], 16'($urandom)};
      end
    endcase
    return v;
  endfunction

  task automatic push_word(input logic [DATA_W-1:0] v, input logic l);
    feed_word_t w;
    w.value = v;
    w.last  = l;
    w.gap   = calm_feed ? 0 : pick_gap();
    w.drain = drain_next;
    drain_next = 1'b0;
    feed_q.push_back(w);
    // words past the capacity are dropped by the block and not counted
    if (feed_pos < SET_CAP) made_items++;
    feed_pos = l ? 0 : feed_pos + 1;
  endtask

  // stimulus
  initial begin
    int                n;
    int                style;
    logic [DATA_W-1:0] base;

    // lone word marked last
    push_word(32'h0000_0000, 1'b1);
    // extremes and duplicates
    push_word(32'h7FFF_FFFF, 1'b0);
    push_word(32'h8000_0000, 1'b0);
    push_word(32'h0000_0000, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'h0000_0001, 1'b0);
    push_word(32'h8000_0000, 1'b1);
    // values that sit on byte-digit boundaries
    push_word(32'h0000_0080, 1'b0);
    push_word(32'hFFFF_FF80, 1'b0);
    push_word(32'h0000_007F, 1'b0);
    push_word(32'h8000_0001, 1'b0);
    push_word(32'h7FFF_FF00, 1'b0);
    push_word(32'h0000_FF00, 1'b0);
    push_word(32'hFF00_0000, 1'b1);
    // descending run
    for (int i = 0; i < 5; i++) push_word(DATA_W'(5 - i), i == 4);
    // wait for the sorter to empty before this set
    drain_next = 1'b1;
    push_word(32'h0001_0000, 1'b0);
    push_word(32'hFFFF_0000, 1'b1);

    // random sets: mostly small, some full, a few overflowing
    while (made_items < ITEM_TARGET) begin
      case ($urandom_range(0, 19))
        0:       n = SET_CAP;
        1:       n = $urandom_range(SET_CAP + 1, SET_CAP + 6);
        default: n = $urandom_range(1, 16);
      endcase
      style      = $urandom_range(0, 3);
      base       = $urandom;
      calm_feed  = ($urandom_range(0, 2) == 0);
      drain_next = ($urandom_range(0, 5) == 0);
      for (int i = 0; i < n; i++) push_word(rand_value(style, base), i == n - 1);
    end

    // let everything in and every sorted word out, then watch for strays
    @(negedge clk);
    while (feed_q.size() != 0 || in_valid || sorted_q.size() != 0) @(negedge clk);
    repeat (100) @(posedge clk);
    if (fault_count == 0 && sorted_q.size() == 0) begin
      $display("lsd_byte_radix_sort_top_tb: PASS");
    end else begin
      $display("lsd_byte_radix_sort_top_tb: FAIL");
    end
    $finish;
  end

  // input driver: advance after each accepted word, idle for each word's random gap
  always @(negedge clk) begin
    feed_word_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (feed_q.size() == 0 || (feed_q[0].drain && sorted_q.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        nxt = feed_q.pop_front();
        in_valid <= 1'b1;
        value    <= nxt.value;
        last     <= nxt.last;
        gap_left = nxt.gap;
      end
    end
  end

  // output back-pressure: random stalls with calm stretches
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(50, 300);
      else if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // monitor: predict on accepted input words, check each accepted output word
  always @(posedge clk) begin
    sorted_word_t want;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) absorb_word(value, last);
      if (out_valid && out_ready) begin
        if (sorted_q.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("unexpected word: sorted_value=%0d last_res=%0b",
                     sorted_value, last_res);
        end else begin
          want = sorted_q.pop_front();
          if (sorted_value !== want.value || last_res !== want.last) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
              $display("mismatch: expected sorted_value=%0d last_res=%0b, got %0d %0b",
                       $signed(want.value), want.last, sorted_value, last_res);
          end
        end
      end
    end
  end

  // give up after a generous fixed time
  initial begin
    #5_000_000;
    $display("lsd_byte_radix_sort_top_tb: FAIL");
    $finish;
  end

endmodule
